@@ hw/rtl/scfp_pkg.sv @@
// Shared types and constants for the serial command frame parser.
// No dependencies; compiled first.
package scfp_pkg;

  localparam int unsigned FrameLen = 11;

  localparam logic [3:0] BCC_POS  = 4'd9;
  localparam logic [3:0] TAIL_POS = 4'd10;

  localparam logic [7:0] HEADER_RESET = 8'd123;
  localparam logic [7:0] TAIL_RESET   = 8'd125;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_TAIL   = 2'd1;

  typedef enum logic [1:0] {
    KIND_VELOCITY = 2'd0,
    KIND_RECHARGE = 2'd1,
    KIND_DOCKING  = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } scfp_kind_e;

  localparam logic [7:0] MODE_VELOCITY  = 8'd0;
  localparam logic [7:0] MODE_RECHARGE0 = 8'd1;
  localparam logic [7:0] MODE_RECHARGE1 = 8'd2;
  localparam logic [7:0] MODE_DOCKING   = 8'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       source_link;
  } scfp_in_t;

  typedef struct packed {
    logic [7:0]        echo_byte;
    logic              echo_link;
    logic              last_of_frame;
    logic [1:0]        command_kind;
    logic [7:0]        mode_value;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] speed_z;
  } scfp_out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } scfp_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept_byte;
    logic echo_next;
  } scfp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_good;
    logic echo_last;
  } scfp_stat_t;

  function automatic scfp_kind_e decode_kind(logic [7:0] mode);
    scfp_kind_e kind;
    if (mode == MODE_VELOCITY) begin
      kind = KIND_VELOCITY;
    end else if (mode == MODE_RECHARGE0 || mode == MODE_RECHARGE1) begin
      kind = KIND_RECHARGE;
    end else if (mode == MODE_DOCKING) begin
      kind = KIND_DOCKING;
    end else begin
      kind = KIND_UNKNOWN;
    end
    return kind;
  endfunction

endpackage

@@ hw/rtl/scfp_intf.sv @@
// Valid/ready channel interfaces for the frame parser.
// Depends on scfp_pkg for the payload types.
interface scfp_in_if;
  import scfp_pkg::*;
  logic     valid;
  logic     ready;
  scfp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfp_out_if;
  import scfp_pkg::*;
  logic      valid;
  logic      ready;
  scfp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfp_cfg_if;
  import scfp_pkg::*;
  logic      valid;
  logic      ready;
  scfp_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/serial_command_frame_parser.sv @@
// Top level of the serial command frame parser: config registers, FSM, datapath.
// Depends on scfp_pkg, scfp_intf, scfp_ctrl and scfp_datapath.
//
//  channel  | dir | payload                                   | transaction
//  in_ch    | in  | rx_byte, source_link                      | valid & ready
//  out_ch   | out | echo byte, link, last flag, decoded cmd   | valid & ready
//  cfg_ch   | in  | register index, 8-bit value               | valid & ready
//
// One received byte per cycle while collecting. After the position-10 tail byte of
// a good frame the FSM echoes the 11 stored bytes, waiting on output stalls; input is
// held off meanwhile. A byte that does not finish a good frame keeps it collecting.
// Reset clears the FSM, index, link and echo counter; config returns to 123/125.
// Config writes are always taken.
module serial_command_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  scfp_in_if.sink           in_ch,
  scfp_out_if.source        out_ch,
  scfp_cfg_if.sink          cfg_ch
);
  import scfp_pkg::*;

  logic [7:0] header_q;
  logic [7:0] tail_q;
  scfp_cmd_t  cmd;
  scfp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      tail_q   <= TAIL_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == REG_HEADER) header_q <= cfg_ch.data.value;
      if (cfg_ch.data.index == REG_TAIL)   tail_q   <= cfg_ch.data.value;
    end
  end

  scfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scfp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_ch.data),
    .header_i   (header_q),
    .tail_i     (tail_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_ch.data)
  );

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken during echo");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.data.last_of_frame) |->
      (out_ch.data.command_kind == 2'd0 && out_ch.data.mode_value == 8'd0))
    else $error("decoded fields set before last echo byte");

  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && out_ch.data.last_of_frame) |=> in_ch.ready)
    else $error("collection did not resume after echo");
`endif

endmodule

@@ hw/rtl/scfp_datapath.sv @@
// Frame assembly datapath: byte store, running BCC, index tracking, echo readout.
// Depends on scfp_pkg.
module scfp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scfp_pkg::scfp_in_t    in_data_i,
  input  logic [7:0]            header_i,
  input  logic [7:0]            tail_i,
  input  scfp_pkg::scfp_cmd_t   cmd_i,
  output scfp_pkg::scfp_stat_t  stat_o,
  output scfp_pkg::scfp_out_t   out_data_o
);
  import scfp_pkg::*;

  logic [7:0] store_q [FrameLen];
  logic [3:0] idx_q, idx_d;
  logic       prev_link_q;
  logic [7:0] bcc_q, bcc_d;
  logic [3:0] echo_q, echo_d;

  logic       link_chg;
  logic [3:0] eff_idx;
  logic       started;
  scfp_kind_e kind;
  logic       last;

  // a link change in mid-frame restarts assembly at position zero
  assign link_chg = (in_data_i.source_link != prev_link_q) && (idx_q != 4'd0);
  assign eff_idx  = link_chg ? 4'd0 : idx_q;
  assign started  = (eff_idx != 4'd0) || (in_data_i.rx_byte == header_i);

  always_comb begin
    idx_d = idx_q;
    bcc_d = bcc_q;
    if (cmd_i.accept_byte) begin
      if (!started || eff_idx == TAIL_POS) begin
        idx_d = 4'd0;
      end else begin
        idx_d = eff_idx + 4'd1;
      end
      if (eff_idx == 4'd0) begin
        bcc_d = in_data_i.rx_byte;
      end else if (eff_idx < BCC_POS) begin
        bcc_d = bcc_q ^ in_data_i.rx_byte;
      end
    end
  end

  assign stat_o.frame_good = (eff_idx == TAIL_POS) && (in_data_i.rx_byte == tail_i)
                           && (store_q[BCC_POS] == bcc_q);

  assign last             = (echo_q == TAIL_POS);
  assign stat_o.echo_last = last;

  always_comb begin
    echo_d = echo_q;
    if (cmd_i.echo_next) begin
      echo_d = last ? 4'd0 : echo_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      prev_link_q <= 1'b0;
      echo_q      <= 4'd0;
    end else begin
      idx_q  <= idx_d;
      echo_q <= echo_d;
      if (cmd_i.accept_byte) begin
        prev_link_q <= in_data_i.source_link;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bcc_q <= bcc_d;
    if (cmd_i.accept_byte) begin
      store_q[eff_idx] <= in_data_i.rx_byte;
    end
  end

  assign kind = decode_kind(store_q[1]);

  always_comb begin
    out_data_o               = '0;
    out_data_o.echo_byte     = store_q[echo_q];
    out_data_o.echo_link     = prev_link_q;
    out_data_o.last_of_frame = last;
    if (last) begin
      out_data_o.command_kind = kind;
      out_data_o.mode_value   = store_q[1];
      if (kind != KIND_UNKNOWN) begin
        out_data_o.speed_x = {store_q[3], store_q[4]};
        out_data_o.speed_y = {store_q[5], store_q[6]};
        out_data_o.speed_z = {store_q[7], store_q[8]};
      end
    end
  end

endmodule

@@ hw/rtl/scfp_ctrl.sv @@
// Controller FSM: collects bytes, then runs the 11-byte echo of a good frame.
// Depends on scfp_pkg.
module scfp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  scfp_pkg::scfp_stat_t  stat_i,
  output scfp_pkg::scfp_cmd_t   cmd_o
);
  import scfp_pkg::*;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_ECHO    = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o        = (state_q == ST_COLLECT);
  assign out_valid_o       = (state_q == ST_ECHO);
  assign cmd_o.accept_byte = in_valid_i && in_ready_o;
  assign cmd_o.echo_next   = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (cmd_o.accept_byte && stat_i.frame_good) state_d = ST_ECHO;
      end
      ST_ECHO: begin
        if (cmd_o.echo_next && stat_i.echo_last) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
